FILE: hdl/cbtf_pkg.sv
// Shared types, constants and helper functions for the caption block timestamp framer.
// Used by the top level; it has no dependencies of its own.
package cbtf_pkg;

  localparam int MAX_BLOCKS = 32;
  localparam int CNT_W      = 6;
  localparam int TIME_W     = 64;
  localparam int ENTRY_W    = 24;
  localparam int ADDR_W     = 3;

  localparam logic [TIME_W-1:0] EOS_TIME_OFFSET = TIME_W'(1001 / 30);
  localparam logic [CNT_W-1:0]  EOS_BLOCK_COUNT = CNT_W'(2);
  localparam logic [7:0]        PAD_BYTE        = 8'h80;
  localparam logic [7:0]        EOS_FIRST_BYTE0 = 8'h04;
  localparam logic [7:0]        EOS_SECOND_BYTE0 = 8'h05;
  localparam logic [1:0]        CC_TYPE_3       = 2'd3;
  localparam logic [1:0]        CC_TYPE_1       = 2'd1;

  // Word index of the keep_padding register (paddr[2]).
  localparam logic REG_KEEP_PAD = 1'b0;

  localparam logic MODE_BLOCK = 1'b0;
  localparam logic MODE_EOS   = 1'b1;
  localparam logic KIND_HDR   = 1'b0;
  localparam logic KIND_BLK   = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PRUNE,
    ST_PRUNE_CHK,
    ST_HDR,
    ST_BLK,
    ST_STORE,
    ST_EOS_HDR,
    ST_EOS_B0,
    ST_EOS_B1
  } state_e;

  // An entry is stored as {byte0, byte1, byte2}.
  function automatic logic is_storable(input logic [7:0] b0);
    return b0[2] || (b0[1:0] == CC_TYPE_3);
  endfunction

  function automatic logic is_trimmable(input logic [ENTRY_W-1:0] e, input logic keep);
    logic pad;
    pad = e[18] && (e[17:16] <= CC_TYPE_1) && !keep &&
          (e[15:8] == PAD_BYTE) && (e[7:0] == PAD_BYTE);
    return pad || !is_storable(e[23:16]);
  endfunction

endpackage

FILE: hdl/cbtf_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// Stand-alone; no package dependencies.
module cbtf_ram #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/caption_block_timestamp_framer_top.sv
// Top level of the caption block timestamp framer: control sequencer, output register,
// configuration port and the block store. Depends on cbtf_pkg and cbtf_ram.
//
// Usage: caption blocks (mode 0) or an end-of-stream marker (mode 1) enter on the input
// valid/ready channel, one transaction per item. Blocks with equal timestamps are kept in
// the block store. A change of timestamp, a full store or an end-of-stream marker flushes
// the group: a header item (previous timestamp, count) and then the stored blocks leave on
// the output valid/ready channel. Trailing padding blocks are trimmed first, one store read
// per cycle, unless keep_padding is set or the store is full. End of stream adds a header and
// two fixed blocks. The last result caused by an input carries last = 1.
// Stored blocks are read out through the single read port of the block store, one entry
// per cycle while the output is not stalled. Only one item is in work at a time. The output
// register lets a new item be accepted while a result waits, and a stall on the output only
// holds the sequencer in its emit states.
// Reset empties the store, sets the previous timestamp to -1 and clears keep_padding.
// The store contents are not cleared; only entries written since are ever read.
module caption_block_timestamp_framer_top #(
  parameter int MaxBlocks = cbtf_pkg::MAX_BLOCKS
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [cbtf_pkg::ADDR_W-1:0]           paddr,
  input  logic [31:0]                           pwdata,
  output logic [31:0]                           prdata,
  output logic                                  pready,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic                                  mode_i,
  input  logic signed [cbtf_pkg::TIME_W-1:0]    timestamp_i,
  input  logic [7:0]                            cc_byte0_i,
  input  logic [7:0]                            cc_byte1_i,
  input  logic [7:0]                            cc_byte2_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic                                  kind_o,
  output logic signed [cbtf_pkg::TIME_W-1:0]    header_time_o,
  output logic [cbtf_pkg::CNT_W-1:0]            block_count_o,
  output logic [7:0]                            out_byte0_o,
  output logic [7:0]                            out_byte1_o,
  output logic [7:0]                            out_byte2_o,
  output logic                                  last_o
);

  localparam int AW = $clog2(MaxBlocks);
  localparam logic [cbtf_pkg::CNT_W-1:0] MaxCnt = cbtf_pkg::CNT_W'(MaxBlocks);

  cbtf_pkg::state_e state_q, state_d;

  logic                                keep_q;
  logic [cbtf_pkg::CNT_W-1:0]          cnt_q, cnt_d;
  logic [AW-1:0]                       idx_q, idx_d;
  logic [cbtf_pkg::TIME_W-1:0]         prev_q, prev_d;
  logic                                mode_q, mode_d;
  logic [cbtf_pkg::TIME_W-1:0]         ts_q, ts_d;
  logic [cbtf_pkg::ENTRY_W-1:0]        blk_q, blk_d;

  logic                                ov_q, ov_d;
  logic                                kind_q, kind_d;
  logic [cbtf_pkg::TIME_W-1:0]         otime_q, otime_d;
  logic [cbtf_pkg::CNT_W-1:0]          ocnt_q, ocnt_d;
  logic [cbtf_pkg::ENTRY_W-1:0]        obytes_q, obytes_d;
  logic                                olast_q, olast_d;

  logic                                mem_we, mem_re;
  logic [AW-1:0]                       mem_waddr, mem_raddr;
  logic [cbtf_pkg::ENTRY_W-1:0]        mem_rdata;

  logic                                slot_free;
  logic                                in_fire;
  logic                                flush;
  logic [cbtf_pkg::CNT_W-1:0]          idx_next;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == cbtf_pkg::REG_KEEP_PAD) ? {31'b0, keep_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_q <= 1'b0;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == cbtf_pkg::REG_KEEP_PAD)) begin
      keep_q <= pwdata[0];
    end
  end

  cbtf_ram #(
    .Width(cbtf_pkg::ENTRY_W),
    .Depth(MaxBlocks)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(blk_q),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  assign in_ready_o = (state_q == cbtf_pkg::ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign slot_free  = !ov_q || out_ready_i;
  assign flush      = ((prev_q != timestamp_i) && (prev_q != '1)) ||
                      (mode_i == cbtf_pkg::MODE_EOS) || (cnt_q == MaxCnt);
  assign idx_next   = cbtf_pkg::CNT_W'(idx_q) + cbtf_pkg::CNT_W'(1);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    prev_d    = prev_q;
    mode_d    = mode_q;
    ts_d      = ts_q;
    blk_d     = blk_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = cnt_q[AW-1:0];
    mem_raddr = cnt_q[AW-1:0] - AW'(1);
    kind_d    = kind_q;
    otime_d   = otime_q;
    ocnt_d    = ocnt_q;
    obytes_d  = obytes_q;
    olast_d   = olast_q;
    ov_d      = out_ready_i ? 1'b0 : ov_q;

    unique case (state_q)
      cbtf_pkg::ST_IDLE: begin
        if (in_fire) begin
          mode_d = mode_i;
          ts_d   = timestamp_i;
          blk_d  = {cc_byte0_i, cc_byte1_i, cc_byte2_i};
          if (flush && (cnt_q != MaxCnt)) begin
            state_d = cbtf_pkg::ST_PRUNE;
          end else if (flush) begin
            state_d = cbtf_pkg::ST_HDR;
          end else begin
            state_d = cbtf_pkg::ST_STORE;
          end
        end
      end
      cbtf_pkg::ST_PRUNE: begin
        if (cnt_q == '0) begin
          state_d = cbtf_pkg::ST_HDR;
        end else begin
          mem_re  = 1'b1;
          state_d = cbtf_pkg::ST_PRUNE_CHK;
        end
      end
      cbtf_pkg::ST_PRUNE_CHK: begin
        if (cbtf_pkg::is_trimmable(mem_rdata, keep_q)) begin
          cnt_d = cnt_q - cbtf_pkg::CNT_W'(1);
          if (cnt_q == cbtf_pkg::CNT_W'(1)) begin
            state_d = cbtf_pkg::ST_HDR;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = cnt_q[AW-1:0] - AW'(2);
          end
        end else begin
          state_d = cbtf_pkg::ST_HDR;
        end
      end
      cbtf_pkg::ST_HDR: begin
        if (cnt_q == '0) begin
          state_d = cbtf_pkg::ST_STORE;
        end else if (slot_free) begin
          ov_d      = 1'b1;
          kind_d    = cbtf_pkg::KIND_HDR;
          otime_d   = prev_q;
          ocnt_d    = cnt_q;
          obytes_d  = '0;
          olast_d   = 1'b0;
          mem_re    = 1'b1;
          mem_raddr = '0;
          idx_d     = '0;
          state_d   = cbtf_pkg::ST_BLK;
        end
      end
      cbtf_pkg::ST_BLK: begin
        if (slot_free) begin
          ov_d     = 1'b1;
          kind_d   = cbtf_pkg::KIND_BLK;
          otime_d  = '0;
          ocnt_d   = '0;
          obytes_d = mem_rdata;
          olast_d  = (idx_next == cnt_q) && (mode_q == cbtf_pkg::MODE_BLOCK);
          if (idx_next == cnt_q) begin
            cnt_d   = '0;
            state_d = cbtf_pkg::ST_STORE;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = idx_next[AW-1:0];
            idx_d     = idx_next[AW-1:0];
          end
        end
      end
      cbtf_pkg::ST_STORE: begin
        if (mode_q == cbtf_pkg::MODE_EOS) begin
          prev_d  = ts_q - cbtf_pkg::EOS_TIME_OFFSET;
          cnt_d   = '0;
          state_d = cbtf_pkg::ST_EOS_HDR;
        end else begin
          prev_d = ts_q;
          if (cbtf_pkg::is_storable(blk_q[23:16]) && (cnt_q < MaxCnt)) begin
            mem_we = 1'b1;
            cnt_d  = cnt_q + cbtf_pkg::CNT_W'(1);
          end
          state_d = cbtf_pkg::ST_IDLE;
        end
      end
      cbtf_pkg::ST_EOS_HDR: begin
        if (slot_free) begin
          ov_d     = 1'b1;
          kind_d   = cbtf_pkg::KIND_HDR;
          otime_d  = prev_q;
          ocnt_d   = cbtf_pkg::EOS_BLOCK_COUNT;
          obytes_d = '0;
          olast_d  = 1'b0;
          state_d  = cbtf_pkg::ST_EOS_B0;
        end
      end
      cbtf_pkg::ST_EOS_B0: begin
        if (slot_free) begin
          ov_d     = 1'b1;
          kind_d   = cbtf_pkg::KIND_BLK;
          otime_d  = '0;
          ocnt_d   = '0;
          obytes_d = {cbtf_pkg::EOS_FIRST_BYTE0, cbtf_pkg::PAD_BYTE, cbtf_pkg::PAD_BYTE};
          olast_d  = 1'b0;
          state_d  = cbtf_pkg::ST_EOS_B1;
        end
      end
      cbtf_pkg::ST_EOS_B1: begin
        if (slot_free) begin
          ov_d     = 1'b1;
          kind_d   = cbtf_pkg::KIND_BLK;
          otime_d  = '0;
          ocnt_d   = '0;
          obytes_d = {cbtf_pkg::EOS_SECOND_BYTE0, cbtf_pkg::PAD_BYTE, cbtf_pkg::PAD_BYTE};
          olast_d  = 1'b1;
          state_d  = cbtf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = cbtf_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cbtf_pkg::ST_IDLE;
      cnt_q   <= '0;
      prev_q  <= '1;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      prev_q  <= prev_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    mode_q   <= mode_d;
    ts_q     <= ts_d;
    blk_q    <= blk_d;
    kind_q   <= kind_d;
    otime_q  <= otime_d;
    ocnt_q   <= ocnt_d;
    obytes_q <= obytes_d;
    olast_q  <= olast_d;
  end

  assign out_valid_o   = ov_q;
  assign kind_o        = kind_q;
  assign header_time_o = otime_q;
  assign block_count_o = ocnt_q;
  assign out_byte0_o   = obytes_q[23:16];
  assign out_byte1_o   = obytes_q[15:8];
  assign out_byte2_o   = obytes_q[7:0];
  assign last_o        = olast_q;

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= MaxCnt)
    else $error("Stored block count exceeds the store depth.");

  a_blk_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cbtf_pkg::ST_BLK) |-> (cbtf_pkg::CNT_W'(idx_q) < cnt_q))
    else $error("Block read index is beyond the group.");

  a_store_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cbtf_pkg::ST_STORE) |=>
      ((state_q == cbtf_pkg::ST_IDLE) || (state_q == cbtf_pkg::ST_EOS_HDR)))
    else $error("Sequencer left the store step for an unexpected state.");

  a_write_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (cbtf_pkg::is_storable(blk_q[23:16]) && (state_q == cbtf_pkg::ST_STORE)))
    else $error("Block store written with an entry that must not be stored.");
`endif

endmodule

FILE: sim/caption_block_timestamp_framer_top_tb.sv
// Testbench for the caption block timestamp framer. It drives caption blocks and end-of-stream
// markers, predicts the header and block stream, and checks every output transaction.
// Depends on cbtf_pkg and caption_block_timestamp_framer_top.
`timescale 1ns / 1ps

module caption_block_timestamp_framer_top_tb;

  localparam int unsigned IDLE_LIMIT    = 4000;
  localparam int unsigned LONG_HOLD     = 300;
  localparam int unsigned SETTLE_CYCLES = 80;
  localparam int unsigned RANDOM_QUOTA  = 8;
  localparam logic [cbtf_pkg::ADDR_W-1:0] KEEP_PAD_ADDR = {cbtf_pkg::REG_KEEP_PAD, 2'b00};
  localparam logic [cbtf_pkg::TIME_W-1:0] NO_STAMP = '1;
  localparam logic [cbtf_pkg::TIME_W-1:0] T_MIN =
    {1'b1, {(cbtf_pkg::TIME_W-1){1'b0}}};
  localparam logic [cbtf_pkg::TIME_W-1:0] T_MAX =
    {1'b0, {(cbtf_pkg::TIME_W-1){1'b1}}};

  typedef struct {
    logic                        kind;
    logic [cbtf_pkg::TIME_W-1:0] header_time;
    logic [cbtf_pkg::CNT_W-1:0]  block_count;
    logic [7:0]                  byte0;
    logic [7:0]                  byte1;
    logic [7:0]                  byte2;
    logic                        last;
  } frame_item_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [cbtf_pkg::ADDR_W-1:0]   paddr = '0;
  logic [31:0]                   pwdata = '0;
  logic [31:0]                   prdata;
  logic                          pready;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic                          mode = cbtf_pkg::MODE_BLOCK;
  logic [cbtf_pkg::TIME_W-1:0]   timestamp = '0;
  logic [7:0]                    cc_byte0 = '0;
  logic [7:0]                    cc_byte1 = '0;
  logic [7:0]                    cc_byte2 = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic                          kind;
  logic [cbtf_pkg::TIME_W-1:0]   header_time;
  logic [cbtf_pkg::CNT_W-1:0]    block_count;
  logic [7:0]                    out_byte0;
  logic [7:0]                    out_byte1;
  logic [7:0]                    out_byte2;
  logic                          last;

  // Predictor state.
  logic [cbtf_pkg::ENTRY_W-1:0]  group_blocks [cbtf_pkg::MAX_BLOCKS];
  int unsigned                   group_len = 0;
  logic [cbtf_pkg::TIME_W-1:0]   prev_stamp = NO_STAMP;
  logic                          keep_pad = 1'b0;
  frame_item_t                   pending_frames [$];
  frame_item_t                   want;

  int unsigned fail_count = 0;
  int unsigned items_sent = 0;
  int unsigned results_checked = 0;
  int unsigned headers_seen = 0;
  int unsigned quiet_cycles = 0;
  int unsigned stall_left = 0;
  int unsigned hold_requested = 0;
  int unsigned hold_granted = 0;
  bit          send_steady = 1'b0;
  bit          recv_steady = 1'b0;

  caption_block_timestamp_framer_top dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .mode_i        (mode),
    .timestamp_i   (timestamp),
    .cc_byte0_i    (cc_byte0),
    .cc_byte1_i    (cc_byte1),
    .cc_byte2_i    (cc_byte2),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .kind_o        (kind),
    .header_time_o (header_time),
    .block_count_o (block_count),
    .out_byte0_o   (out_byte0),
    .out_byte1_o   (out_byte1),
    .out_byte2_o   (out_byte2),
    .last_o        (last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic push_frame(input logic k, input logic [cbtf_pkg::TIME_W-1:0] t,
                            input logic [cbtf_pkg::CNT_W-1:0] n, input logic [7:0] b0,
                            input logic [7:0] b1, input logic [7:0] b2);
    frame_item_t f;
    f.kind = k;
    f.header_time = t;
    f.block_count = n;
    f.byte0 = b0;
    f.byte1 = b1;
    f.byte2 = b2;
    f.last = 1'b0;
    pending_frames.push_back(f);
  endtask

  task automatic frame_input(input logic item_mode, input logic [cbtf_pkg::TIME_W-1:0] stamp,
                             input logic [7:0] b0, input logic [7:0] b1, input logic [7:0] b2);
    logic [cbtf_pkg::ENTRY_W-1:0] tail;
    logic [cbtf_pkg::TIME_W-1:0]  next_stamp;
    int unsigned                  depth_before;
    depth_before = pending_frames.size();
    next_stamp = stamp;
    if ((prev_stamp != stamp && prev_stamp != NO_STAMP) || item_mode == cbtf_pkg::MODE_EOS ||
        group_len == cbtf_pkg::MAX_BLOCKS) begin
      if (group_len != cbtf_pkg::MAX_BLOCKS) begin
        while (group_len > 0) begin
          tail = group_blocks[group_len-1];
          if ((tail[18] && tail[17:16] <= cbtf_pkg::CC_TYPE_1 && !keep_pad &&
               tail[15:8] == cbtf_pkg::PAD_BYTE && tail[7:0] == cbtf_pkg::PAD_BYTE) ||
              !(tail[18] || tail[17:16] == cbtf_pkg::CC_TYPE_3))
            group_len--;
          else
            break;
        end
      end
      if (group_len > 0) begin
        push_frame(cbtf_pkg::KIND_HDR, prev_stamp, cbtf_pkg::CNT_W'(group_len), '0, '0, '0);
        for (int i = 0; i < group_len; i++)
          push_frame(cbtf_pkg::KIND_BLK, '0, '0, group_blocks[i][23:16],
                     group_blocks[i][15:8], group_blocks[i][7:0]);
      end
      group_len = 0;
    end
    if (item_mode == cbtf_pkg::MODE_BLOCK) begin
      if ((b0[2] || b0[1:0] == cbtf_pkg::CC_TYPE_3) && group_len < cbtf_pkg::MAX_BLOCKS) begin
        group_blocks[group_len] = {b0, b1, b2};
        group_len++;
      end
    end else begin
      next_stamp = stamp - cbtf_pkg::EOS_TIME_OFFSET;
      push_frame(cbtf_pkg::KIND_HDR, next_stamp, cbtf_pkg::EOS_BLOCK_COUNT, '0, '0, '0);
      push_frame(cbtf_pkg::KIND_BLK, '0, '0, cbtf_pkg::EOS_FIRST_BYTE0, cbtf_pkg::PAD_BYTE,
                 cbtf_pkg::PAD_BYTE);
      push_frame(cbtf_pkg::KIND_BLK, '0, '0, cbtf_pkg::EOS_SECOND_BYTE0, cbtf_pkg::PAD_BYTE,
                 cbtf_pkg::PAD_BYTE);
      group_len = 0;
    end
    prev_stamp = next_stamp;
    if (pending_frames.size() > depth_before)
      pending_frames[pending_frames.size()-1].last = 1'b1;
  endtask

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      frame_input(mode, timestamp, cc_byte0, cc_byte1, cc_byte2);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_checked++;
      if (kind == cbtf_pkg::KIND_HDR)
        headers_seen++;
      if (pending_frames.size() == 0) begin
        $error("Output transaction with nothing expected: kind %0d", kind);
        fail_count++;
      end else begin
        want = pending_frames.pop_front();
        if (kind !== want.kind) begin
          $error("kind: expected %0d, actual %0d", want.kind, kind);
          fail_count++;
        end
        if (header_time !== want.header_time) begin
          $error("header_time: expected %h, actual %h", want.header_time, header_time);
          fail_count++;
        end
        if (block_count !== want.block_count) begin
          $error("block_count: expected %0d, actual %0d", want.block_count, block_count);
          fail_count++;
        end
        if (out_byte0 !== want.byte0) begin
          $error("out_byte0: expected %h, actual %h", want.byte0, out_byte0);
          fail_count++;
        end
        if (out_byte1 !== want.byte1) begin
          $error("out_byte1: expected %h, actual %h", want.byte1, out_byte1);
          fail_count++;
        end
        if (out_byte2 !== want.byte2) begin
          $error("out_byte2: expected %h, actual %h", want.byte2, out_byte2);
          fail_count++;
        end
        if (last !== want.last) begin
          $error("last: expected %0d, actual %0d", want.last, last);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left <= 0;
    end else if (hold_granted != hold_requested) begin
      hold_granted <= hold_requested;
      stall_left <= LONG_HOLD;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (!recv_steady && $urandom_range(0, 99) < 20) begin
      stall_left <= ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(10, 40);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(input logic item_mode, input logic [cbtf_pkg::TIME_W-1:0] stamp,
                           input logic [7:0] b0, input logic [7:0] b1, input logic [7:0] b2);
    int unsigned gap;
    int unsigned roll;
    gap = 0;
    if (!send_steady) begin
      roll = $urandom_range(0, 99);
      if (roll < 15)
        gap = $urandom_range(1, 3);
      else if (roll < 20)
        gap = $urandom_range(8, 30);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= item_mode;
    timestamp <= stamp;
    cc_byte0 <= b0;
    cc_byte1 <= b1;
    cc_byte2 <= b2;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_frames.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_keep_pad(input logic value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= KEEP_PAD_ADDR;
    pwdata <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    keep_pad = value;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== 32'(value)) begin
      $error("prdata: expected %h, actual %h", 32'(value), prdata);
      fail_count++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic test_directed_groups();
    send_item(cbtf_pkg::MODE_BLOCK, NO_STAMP, 8'hFC, 8'h00, 8'hFF);
    send_item(cbtf_pkg::MODE_BLOCK, 64'd100, 8'h07, 8'hFF, 8'h00);
    send_item(cbtf_pkg::MODE_BLOCK, 64'd100, 8'h03, 8'h12, 8'h34);
    send_item(cbtf_pkg::MODE_BLOCK, 64'd100, 8'h00, 8'hAA, 8'h55);
    send_item(cbtf_pkg::MODE_BLOCK, 64'd100, 8'h04, cbtf_pkg::PAD_BYTE, cbtf_pkg::PAD_BYTE);
    send_item(cbtf_pkg::MODE_BLOCK, 64'd100, 8'h05, cbtf_pkg::PAD_BYTE, cbtf_pkg::PAD_BYTE);
    send_item(cbtf_pkg::MODE_BLOCK, 64'd200, 8'h04, cbtf_pkg::PAD_BYTE, cbtf_pkg::PAD_BYTE);
    send_item(cbtf_pkg::MODE_BLOCK, 64'd200, 8'hF5, cbtf_pkg::PAD_BYTE, cbtf_pkg::PAD_BYTE);
    send_item(cbtf_pkg::MODE_BLOCK, 64'd300, 8'h05, cbtf_pkg::PAD_BYTE, 8'h81);
    send_item(cbtf_pkg::MODE_EOS, T_MIN, 8'hFF, 8'hFF, 8'hFF);
    send_item(cbtf_pkg::MODE_BLOCK, T_MAX, 8'hFF, 8'hFF, 8'hFF);
    send_item(cbtf_pkg::MODE_EOS, 64'd0, 8'h00, 8'h00, 8'h00);
    send_item(cbtf_pkg::MODE_EOS, 64'd33, 8'h5A, 8'hA5, 8'h3C);
    send_item(cbtf_pkg::MODE_BLOCK, NO_STAMP, 8'h06, 8'h01, 8'h02);
    send_item(cbtf_pkg::MODE_BLOCK, 64'd5, 8'h0B, cbtf_pkg::PAD_BYTE, cbtf_pkg::PAD_BYTE);
    send_item(cbtf_pkg::MODE_BLOCK, 64'd5, 8'h04, cbtf_pkg::PAD_BYTE, cbtf_pkg::PAD_BYTE);
    send_item(cbtf_pkg::MODE_EOS, NO_STAMP, 8'hC3, 8'h3C, 8'h99);
    drain_results();
  endtask

  task automatic test_keep_padding();
    write_keep_pad(1'b1);
    send_item(cbtf_pkg::MODE_BLOCK, 64'd1000, 8'h05, cbtf_pkg::PAD_BYTE, cbtf_pkg::PAD_BYTE);
    send_item(cbtf_pkg::MODE_BLOCK, 64'd1000, 8'h14, 8'h41, 8'h42);
    send_item(cbtf_pkg::MODE_BLOCK, 64'd1000, 8'h04, cbtf_pkg::PAD_BYTE, cbtf_pkg::PAD_BYTE);
    send_item(cbtf_pkg::MODE_BLOCK, 64'd1000, 8'h05, cbtf_pkg::PAD_BYTE, cbtf_pkg::PAD_BYTE);
    send_item(cbtf_pkg::MODE_BLOCK, 64'd1001, 8'h07, cbtf_pkg::PAD_BYTE, cbtf_pkg::PAD_BYTE);
    send_item(cbtf_pkg::MODE_BLOCK, 64'd1001, 8'h04, cbtf_pkg::PAD_BYTE, cbtf_pkg::PAD_BYTE);
    send_item(cbtf_pkg::MODE_EOS, 64'd2000, 8'h00, 8'h00, 8'h00);
    drain_results();
    write_keep_pad(1'b0);
  endtask

  task automatic test_full_store();
    logic [7:0] b0;
    send_steady = 1'b1;
    recv_steady = 1'b1;
    for (int i = 0; i < cbtf_pkg::MAX_BLOCKS + 1; i++) begin
      if (i % cbtf_pkg::MAX_BLOCKS >= cbtf_pkg::MAX_BLOCKS - 3) begin
        send_item(cbtf_pkg::MODE_BLOCK, 64'd5000, {7'h00, 1'(i)} | 8'h04,
                  cbtf_pkg::PAD_BYTE, cbtf_pkg::PAD_BYTE);
      end else begin
        b0 = 8'($urandom) | 8'h04;
        send_item(cbtf_pkg::MODE_BLOCK, 64'd5000, b0, 8'($urandom), 8'($urandom));
      end
    end
    send_item(cbtf_pkg::MODE_EOS, 64'd5000, 8'h00, 8'h00, 8'h00);
    drain_results();
    send_steady = 1'b0;
    recv_steady = 1'b0;
  endtask

  task automatic test_backpressure();
    send_steady = 1'b1;
    hold_requested++;
    for (int i = 0; i < 12; i++)
      send_item(cbtf_pkg::MODE_BLOCK, 64'(7000 + i / 2), 8'h04 | 8'($urandom),
                8'($urandom), 8'($urandom));
    send_item(cbtf_pkg::MODE_EOS, 64'd8000, 8'h00, 8'h00, 8'h00);
    drain_results();
    send_steady = 1'b0;
  endtask

  task automatic test_random_traffic(input int unsigned quota);
    int unsigned                 counted;
    int unsigned                 group_size;
    int unsigned                 roll;
    logic [cbtf_pkg::TIME_W-1:0] stamp;
    logic [7:0]                  b0;
    logic [7:0]                  b1;
    logic [7:0]                  b2;
    counted = 0;
    stamp = {$urandom(), $urandom()};
    while (counted < quota) begin
      roll = $urandom_range(0, 99);
      if (roll < 65)
        stamp = stamp + $urandom_range(1, 40);
      else if (roll < 85 && roll >= 75)
        stamp = NO_STAMP;
      else if (roll >= 85)
        stamp = {$urandom(), $urandom()};
      group_size = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 36) : $urandom_range(1, 6);
      for (int k = 0; k < group_size && counted < quota; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < 35) begin
          b0 = {5'($urandom), 1'b1, 1'b0, 1'($urandom)};
          b1 = cbtf_pkg::PAD_BYTE;
          b2 = cbtf_pkg::PAD_BYTE;
        end else if (roll < 50) begin
          b0 = {5'($urandom), 1'b0, 2'($urandom_range(0, 2))};
          b1 = 8'($urandom);
          b2 = 8'($urandom);
        end else begin
          b0 = 8'($urandom);
          b1 = 8'($urandom);
          b2 = 8'($urandom);
        end
        send_item(cbtf_pkg::MODE_BLOCK, stamp, b0, b1, b2);
        counted++;
      end
      if ($urandom_range(0, 9) == 0) begin
        if ($urandom_range(0, 1) == 1)
          stamp = {$urandom(), $urandom()};
        send_item(cbtf_pkg::MODE_EOS, stamp, 8'($urandom), 8'($urandom), 8'($urandom));
        counted++;
      end
    end
    drain_results();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_keep_pad(1'b0);
    test_directed_groups();
    test_keep_padding();
    test_full_store();
    test_backpressure();
    for (int phase = 0; phase < 4; phase++) begin
      write_keep_pad(phase[0] == 1'b0);
      test_random_traffic(RANDOM_QUOTA);
    end
    $display("Covered %0d input transactions and %0d output transactions (%0d headers),",
             items_sent, results_checked, headers_seen);
    $display("with padding kept and pruned, full-store flushes, end of stream and back-pressure.");
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
